[rtl/ord_pkg.sv]
// Package for the output-restricted deque: command, status and cell-operation codes,
// the request and result item structs, and default sizes.
// No dependencies.
`default_nettype none

package ord_pkg;

	// Default storage sizes.
	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed widths of the item fields.
	localparam int VALUE_W = 32;

	// Command codes carried by a request item.
	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_LIST       = 2'd3
	} cmd_e_t;

	// Status codes carried by a result item.
	typedef enum logic [2:0] {
		STAT_INSERTED = 3'd0,
		STAT_POPPED   = 3'd1,
		STAT_EMPTY    = 3'd2,
		STAT_LISTED   = 3'd3,
		STAT_FULL     = 3'd4
	} status_e_t;

	// Operation broadcast to every cell of the row at once.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP,
		OP_ROTATE
	} cell_op_e_t;

	// Controller states.
	typedef enum logic {
		S_IDLE,
		S_LIST
	} state_e_t;

	typedef struct packed {
		cmd_e_t                     cmd;
		logic signed [VALUE_W-1:0]  value;
	} req_t;

	typedef struct packed {
		status_e_t                  status;
		logic signed [VALUE_W-1:0]  item;
		logic                       last;
	} res_t;

endpackage

`default_nettype wire

[rtl/ord_cell.sv]
// One storage cell of the deque row: a data word and an occupied flag.
// Takes data from its left or right neighbor, the new item value or the head word,
// as the broadcast operation says. Depends on ord_pkg.
`default_nettype none

module ord_cell #(
	parameter int DATA_WIDTH = ord_pkg::DATA_WIDTH_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  ord_pkg::cell_op_e_t       op,
	input  wire  [DATA_WIDTH-1:0]     new_d,
	input  wire  [DATA_WIDTH-1:0]     head_d,
	input  wire  [DATA_WIDTH-1:0]     left_d,
	input  wire                       left_v,
	input  wire  [DATA_WIDTH-1:0]     right_d,
	input  wire                       right_v,
	output logic [DATA_WIDTH-1:0]     d,
	output logic                      v
);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  vld_q;
	logic [DATA_WIDTH-1:0] data_n;
	logic                  vld_n;

	// Next contents of this cell for each row operation.
	always_comb begin
		data_n = data_q;
		vld_n  = vld_q;
		unique case (op)
			ord_pkg::OP_HOLD: begin
			end
			ord_pkg::OP_PUSH_FRONT: begin
				data_n = left_d;
				vld_n  = left_v;
			end
			ord_pkg::OP_PUSH_BACK: begin
				// The first free cell behind the occupied run takes the new value.
				if (!vld_q && left_v) begin
					data_n = new_d;
					vld_n  = 1'b1;
				end
			end
			ord_pkg::OP_POP: begin
				data_n = right_d;
				vld_n  = right_v;
			end
			ord_pkg::OP_ROTATE: begin
				// The occupied run turns by one: the tail takes the head word.
				if (vld_q && !right_v) begin
					data_n = head_d;
				end else if (vld_q) begin
					data_n = right_d;
				end
			end
			default: begin
			end
		endcase
	end

	// Occupied flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_n;
		end
	end

	// Data word, meaningful only while occupied.
	always_ff @(posedge clk) begin
		data_q <= data_n;
	end

	assign d = data_q;
	assign v = vld_q;

endmodule

`default_nettype wire

[rtl/output_restricted_deque.sv]
// Top level of the output-restricted deque: controller, occupancy count and the row of cells.
// Depends on ord_pkg and ord_cell.
//
// Push front, push back and pop front may follow one another in every cycle; the result
// item appears on the result port in the cycle after the request is accepted. A list
// command on a non-empty queue holds busy high while its entries are read out, one listed
// item per cycle, because the row of cells turns by one position each cycle and the head
// cell is read out; after a full turn the order is restored. A list or pop on an empty
// queue gives one empty result. Each result is shown for exactly one cycle under strobe
// and cannot be held off by the receiver.
`default_nettype none

module output_restricted_deque #(
	parameter int DEPTH      = ord_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ord_pkg::DATA_WIDTH_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  ord_pkg::req_t   request,
	output logic            busy,
	output logic            strobe,
	output ord_pkg::res_t   result
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (DATA_WIDTH > ord_pkg::VALUE_W) ? DATA_WIDTH : ord_pkg::VALUE_W;

	ord_pkg::state_e_t    state_q, state_d;
	logic [CW-1:0]        count_q, count_d;
	logic [CW-1:0]        remain_q, remain_d;
	logic                 strobe_q, strobe_d;
	ord_pkg::res_t        result_q, result_d;
	ord_pkg::cell_op_e_t  op;

	logic [DATA_WIDTH-1:0] cell_d [DEPTH];
	logic                  cell_v [DEPTH];
	logic [DATA_WIDTH-1:0] new_d;
	logic [EW-1:0]         value_ext;
	logic [EW-1:0]         head_ext;
	logic signed [ord_pkg::VALUE_W-1:0] head_item;
	logic                  accept;
	logic                  full;
	logic                  empty;

	// Width fitting between item fields and stored words.
	assign value_ext = EW'(unsigned'(request.value));
	assign new_d     = value_ext[DATA_WIDTH-1:0];
	assign head_ext  = EW'(cell_d[0]);
	assign head_item = signed'(head_ext[ord_pkg::VALUE_W-1:0]);

	assign accept = start && (state_q == ord_pkg::S_IDLE);
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);

	// Row of cells, each linked to its two neighbors.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] l_d, r_d;
		logic                  l_v, r_v;
		if (i == 0) begin : g_first
			assign l_d = new_d;
			assign l_v = 1'b1;
		end else begin : g_mid_l
			assign l_d = cell_d[i-1];
			assign l_v = cell_v[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign r_d = '0;
			assign r_v = 1'b0;
		end else begin : g_mid_r
			assign r_d = cell_d[i+1];
			assign r_v = cell_v[i+1];
		end
		ord_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (op),
			.new_d   (new_d),
			.head_d  (cell_d[0]),
			.left_d  (l_d),
			.left_v  (l_v),
			.right_d (r_d),
			.right_v (r_v),
			.d       (cell_d[i]),
			.v       (cell_v[i])
		);
	end

	// Next state, row operation and result item.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		remain_d = remain_q;
		op       = ord_pkg::OP_HOLD;
		strobe_d = 1'b0;
		result_d = '{status: ord_pkg::STAT_INSERTED, item: '0, last: 1'b1};
		unique case (state_q)
			ord_pkg::S_IDLE: begin
				if (accept) begin
					strobe_d = 1'b1;
					unique case (request.cmd)
						ord_pkg::CMD_PUSH_FRONT, ord_pkg::CMD_PUSH_BACK: begin
							if (full) begin
								result_d.status = ord_pkg::STAT_FULL;
							end else begin
								op = (request.cmd == ord_pkg::CMD_PUSH_FRONT) ?
									ord_pkg::OP_PUSH_FRONT : ord_pkg::OP_PUSH_BACK;
								count_d = count_q + 1'b1;
							end
						end
						ord_pkg::CMD_POP_FRONT: begin
							if (empty) begin
								result_d.status = ord_pkg::STAT_EMPTY;
							end else begin
								result_d.status = ord_pkg::STAT_POPPED;
								result_d.item   = head_item;
								op              = ord_pkg::OP_POP;
								count_d         = count_q - 1'b1;
							end
						end
						ord_pkg::CMD_LIST: begin
							if (empty) begin
								result_d.status = ord_pkg::STAT_EMPTY;
							end else begin
								strobe_d = 1'b0;
								state_d  = ord_pkg::S_LIST;
								remain_d = count_q;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ord_pkg::S_LIST: begin
				// Read the head and turn the row by one entry.
				op              = ord_pkg::OP_ROTATE;
				strobe_d        = 1'b1;
				result_d.status = ord_pkg::STAT_LISTED;
				result_d.item   = head_item;
				result_d.last   = (remain_q == CW'(1));
				remain_d        = remain_q - 1'b1;
				if (remain_q == CW'(1)) begin
					state_d = ord_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ord_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ord_pkg::S_IDLE;
			count_q  <= '0;
			remain_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			remain_q <= remain_d;
			strobe_q <= strobe_d;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign busy   = (state_q == ord_pkg::S_LIST);
	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire

[rtl/ord_checker.sv]
// Port-level checker for the output-restricted deque and its bind to the top level.
// Depends on ord_pkg and output_restricted_deque.
`default_nettype none

module ord_checker (
	input wire             clk,
	input wire             arst_n,
	input wire             start,
	input ord_pkg::req_t   request,
	input wire             busy,
	input wire             strobe,
	input ord_pkg::res_t   result
);

	// A push or pop item gives its result in the next cycle.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.cmd != ord_pkg::CMD_LIST)) |=> strobe)
		else $error("push or pop item gave no result in the next cycle");

	// Every cycle spent listing yields a result in the following cycle.
	a_list_stream: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> strobe)
		else $error("listing cycle gave no result");

	// A result that is not the last one of its item belongs to a list still running.
	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |-> (busy && (result.status == ord_pkg::STAT_LISTED)))
		else $error("non-final result outside a list");

	// The final listed entry comes out once the block is free again.
	a_list_end: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last && (result.status == ord_pkg::STAT_LISTED)) |-> !busy)
		else $error("final listed entry while still busy");

endmodule

bind output_restricted_deque ord_checker u_ord_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.request (request),
	.busy    (busy),
	.strobe  (strobe),
	.result  (result)
);

`default_nettype wire

[tb/ord_result_checker.sv]
// Result checker for the output-restricted deque: keeps its own ring store, front index and
// occupancy, works out the answers of every accepted command and compares each result item.
// Depends on ord_pkg; hands the failure count and the number of answers still due to the top.
module ord_result_checker #(
	parameter int DEPTH      = ord_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = ord_pkg::DATA_WIDTH_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	input  wire           busy,
	input  ord_pkg::req_t request,
	input  wire           strobe,
	input  ord_pkg::res_t result,
	output int            failures,
	output int            pending
);
	import ord_pkg::*;

	// Shadow copy of the deque contents.
	logic [DATA_WIDTH-1:0] ring [DEPTH];
	int unsigned           head;
	int unsigned           count;

	// Answers still to come, oldest first.
	res_t answers_due [$];
	int   tally;

	// Apply one command to the shadow deque and queue the answers it causes.
	task automatic answer_command(input req_t req);
		res_t        ans;
		int unsigned slot;
		int unsigned i;
		ans.status = STAT_EMPTY;
		ans.item   = '0;
		ans.last   = 1'b1;
		case (req.cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (count >= DEPTH) begin
					ans.status = STAT_FULL;
				end else begin
					if (req.cmd == CMD_PUSH_FRONT) begin
						head = (head + DEPTH - 1) % DEPTH;
						slot = head;
					end else begin
						slot = (head + count) % DEPTH;
					end
					ring[slot] = DATA_WIDTH'(req.value);
					count++;
					ans.status = STAT_INSERTED;
				end
				answers_due.push_back(ans);
			end
			CMD_POP_FRONT: begin
				if (count != 0) begin
					ans.status = STAT_POPPED;
					ans.item   = VALUE_W'(ring[head]);
					head       = (head + 1) % DEPTH;
					count--;
				end
				answers_due.push_back(ans);
			end
			default: begin
				// A list leaves the deque as it is: one item per entry, front to back.
				if (count == 0) begin
					answers_due.push_back(ans);
				end else begin
					for (i = 0; i < count; i++) begin
						ans.status = STAT_LISTED;
						ans.item   = VALUE_W'(ring[(head + i) % DEPTH]);
						ans.last   = (i + 1 == count);
						answers_due.push_back(ans);
					end
				end
			end
		endcase
	endtask

	// Compare one result item with the oldest answer due.
	task automatic compare_result(input res_t got);
		res_t want;
		if (answers_due.size() == 0) begin
			$error("result with nothing due: status %0d item %0d last %0d",
				got.status, got.item, got.last);
			tally++;
		end else begin
			want = answers_due.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				tally++;
			end
			if (got.item !== want.item) begin
				$error("item: expected %0d, actual %0d", want.item, got.item);
				tally++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				tally++;
			end
		end
	endtask

	// Watch both channels at every rising edge; the command is taken before the result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head  = 0;
			count = 0;
			tally = 0;
			answers_due.delete();
			failures <= 0;
			pending  <= 0;
		end else begin
			if (start && !busy)
				answer_command(request);
			if (strobe)
				compare_result(result);
			failures <= tally;
			pending  <= answers_due.size();
		end
	end

endmodule

[tb/output_restricted_deque_tb.sv]
// Top of the deque testbench: clock, reset and command stimulus with random gaps.
// Depends on ord_pkg, output_restricted_deque and ord_result_checker; gives the verdict.
module output_restricted_deque_tb;
	import ord_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 20;

	logic clk;
	logic arst_n;
	logic start;
	req_t request;
	logic busy;
	logic strobe;
	res_t result;
	int   failures;
	int   pending;
	int   cycle_count;
	int   issued;
	bit   steady;

	output_restricted_deque uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.strobe  (strobe),
		.result  (result)
	);

	ord_result_checker #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH_DEF)
	) answer_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.strobe   (strobe),
		.result   (result),
		.failures (failures),
		.pending  (pending)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Guard against a hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Send one command item after a random gap; returns at the edge that accepts it.
	// Every sixteen items the sender decides whether to run without gaps for a while.
	task automatic issue(input cmd_e_t op, input logic signed [VALUE_W-1:0] val);
		int   gap;
		req_t r;
		if (issued % 16 == 0)
			steady = ($urandom_range(0, 2) == 0);
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.cmd   = op;
		r.value = val;
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		issued++;
	endtask

	// Random commands; pushes weigh in at half so the deque tends to grow.
	task automatic issue_mixed(input int n);
		int k;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 3))
				0:       issue(CMD_PUSH_FRONT, $urandom);
				1:       issue(CMD_PUSH_BACK, $urandom);
				2:       issue(CMD_POP_FRONT, $urandom);
				default: issue(CMD_LIST, $urandom);
			endcase
		end
	endtask

	initial begin
		int k;
		arst_n      = 1'b0;
		start       = 1'b0;
		request     = '0;
		cycle_count = 0;
		issued      = 0;
		steady      = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty cases, extreme values, front index wrap, lists and a full drain.
		issue(CMD_POP_FRONT, 32'sd0);
		issue(CMD_LIST, 32'sd0);
		issue(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
		issue(CMD_PUSH_FRONT, 32'sh8000_0000);
		issue(CMD_PUSH_BACK, -32'sd1);
		issue(CMD_PUSH_FRONT, 32'sd0);
		issue(CMD_LIST, 32'sh1234_5678);
		issue(CMD_POP_FRONT, -32'sd1);
		issue(CMD_POP_FRONT, 32'sd0);
		issue(CMD_PUSH_BACK, 32'sh5555_5555);
		issue(CMD_PUSH_FRONT, 32'shAAAA_AAAA);
		issue(CMD_LIST, -32'sd1);
		for (k = 0; k < 4; k++)
			issue(CMD_POP_FRONT, $urandom);
		issue(CMD_POP_FRONT, $urandom);
		issue(CMD_LIST, $urandom);

		// Random: mixed traffic, fill past full, list a full deque, drain past empty.
		issue_mixed(6);
		for (k = 0; k < DEPTH + 2; k++)
			issue($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $urandom);
		issue(CMD_LIST, $urandom);
		for (k = 0; k < DEPTH + 2; k++)
			issue(CMD_POP_FRONT, $urandom);
		issue_mixed(6);
		start <= 1'b0;

		// Let every answer arrive, then stay idle to catch stray results.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[output_restricted_deque.f]
rtl/ord_pkg.sv
rtl/ord_cell.sv
rtl/output_restricted_deque.sv
rtl/ord_checker.sv
tb/ord_result_checker.sv
tb/output_restricted_deque_tb.sv
